### sv/ssg_pkg.sv
// Shared types, widths and constants of the spike-shape sample generator.
// No dependencies; every module of the block imports it.
package ssg_pkg;

  localparam int MAX_LENGTH    = 4096;
  localparam int AMP_FRAC_BITS = 15;

  localparam int IDX_W  = 12;
  localparam int LEN_W  = 13;
  localparam int SEL_W  = 2;
  localparam int AMP_W  = 16;
  localparam int CIDX_W = 2;

  // divider: numerator, denominator and quotient widths
  localparam int NUM_W  = 43;
  localparam int DEN_W  = 25;
  localparam int QUOT_W = 19;

  // 2^-y unit: Q16 fraction, Q30 mantissa
  localparam int FRAC_W = 16;
  localparam int R_W    = 30;
  localparam int M_W    = 31;
  localparam int EXP_W  = QUOT_W - FRAC_W;

  localparam logic [16:0] LOG2E_Q16   = 17'd94548;
  localparam logic [17:0] LOG2_10_Q16 = 18'd217706;
  // floor(d / 5) == (d * 52429) >> 18 for every length in range
  localparam logic [15:0] DIV5_MUL    = 16'd52429;
  localparam int          DIV5_SHIFT  = 18;

  localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(1 << AMP_FRAC_BITS);

  localparam logic [SEL_W-1:0] SHAPE_BOX  = 2'd0;
  localparam logic [SEL_W-1:0] SHAPE_TRI  = 2'd1;
  localparam logic [SEL_W-1:0] SHAPE_BELL = 2'd2;
  localparam logic [SEL_W-1:0] SHAPE_EXP  = 2'd3;

  localparam logic [CIDX_W-1:0] REG_SHAPE  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_LENGTH = 2'd1;

  localparam logic [1:0] MODE_ZERO = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_DIV  = 2'd2;
  localparam logic [1:0] MODE_POW  = 2'd3;

  typedef struct packed {
    logic       in_range;
    logic [1:0] mode;
  } ctl_t;

  typedef logic [R_W-1:0] r_tab_t [FRAC_W];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = 64'd0;
    b   = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // entry j is 2^-(2^(-1-j)) in Q30, used for fraction bit FRAC_W-1-j
  function automatic r_tab_t gen_r_tab();
    r_tab_t      tab;
    logic [63:0] r;
    r = isqrt64(64'd1 << 59);
    for (int j = 0; j < FRAC_W; j++) begin
      tab[j] = r[R_W-1:0];
      r      = isqrt64(r << 30);
    end
    return tab;
  endfunction

  localparam r_tab_t R_TAB = gen_r_tab();

endpackage

### sv/spike_shape_sample_generator_top.sv
// An accepted input beat passes through 5 front stages, 19 divider stages,
// 16 multiply stages and 1 output stage on its way to its output beat.
// Throughput: one beat per cycle; the whole pipeline holds while out_stall
// is high and a beat waits at the output.
// Reset (synchronous, rst_n low): pipeline empties, shape resets to square,
// length to 1.
module spike_shape_sample_generator_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ssg_pkg::CIDX_W-1:0] cfg_index,
  input  logic [ssg_pkg::LEN_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ssg_pkg::IDX_W-1:0]  in_sample_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ssg_pkg::AMP_W-1:0]  out_amplitude,
  output logic                       out_in_range
);
  import ssg_pkg::*;

  logic [SEL_W-1:0] shape_r;
  logic [LEN_W-1:0] len_r;
  logic             en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= SHAPE_BOX;
      len_r   <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHAPE:  shape_r <= cfg_wdata[SEL_W-1:0];
        REG_LENGTH: len_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: clamp length, range check, distance from center
  logic [LEN_W-1:0] d_in;
  logic [LEN_W-1:0] two_x1;
  logic [LEN_W-1:0] t_in;
  logic             s1_v_r;
  logic [IDX_W-1:0] s1_x_r;
  logic [LEN_W-1:0] s1_d_r;
  logic [IDX_W-1:0] s1_t_r;
  logic             s1_inr_r;
  logic [SEL_W-1:0] s1_shape_r;

  assign d_in   = (len_r > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : len_r;
  assign two_x1 = {in_sample_index, 1'b1};
  assign t_in   = (two_x1 >= d_in) ? two_x1 - d_in : d_in - two_x1;

  // stage 2: squares and the divide-by-five product
  logic             s2_v_r;
  logic [IDX_W-1:0] s2_x_r;
  logic [LEN_W-1:0] s2_d_r;
  logic [IDX_W-1:0] s2_t_r;
  logic             s2_inr_r;
  logic [SEL_W-1:0] s2_shape_r;
  logic [23:0]      s2_tt_r;
  logic [DEN_W-1:0] s2_dd_r;
  logic [28:0]      s2_d5_r;

  // stage 3: flat part and gaussian numerator
  logic             s3_v_r;
  logic [IDX_W-1:0] s3_x_r;
  logic [LEN_W-1:0] s3_d_r;
  logic [IDX_W-1:0] s3_t_r;
  logic             s3_inr_r;
  logic [SEL_W-1:0] s3_shape_r;
  logic [DEN_W-1:0] s3_dd_r;
  logic [LEN_W-1:0] s3_flat_r;
  logic [40:0]      s3_gnum_r;

  // stage 4: decay offset and span
  logic             s4_v_r;
  logic [LEN_W-1:0] s4_d_r;
  logic [IDX_W-1:0] s4_t_r;
  logic             s4_inr_r;
  logic [SEL_W-1:0] s4_shape_r;
  logic [DEN_W-1:0] s4_dd_r;
  logic [40:0]      s4_gnum_r;
  logic [IDX_W-1:0] s4_xm_r;
  logic [LEN_W-1:0] s4_span_r;
  logic             s4_flat_r;

  // stage 5: divider operands
  logic [29:0]      enum_prod;
  logic [NUM_W-1:0] num_nxt;
  logic [DEN_W-1:0] den_nxt;
  ctl_t             ctl_nxt;
  logic             s5_v_r;
  logic [NUM_W-1:0] s5_num_r;
  logic [DEN_W-1:0] s5_den_r;
  ctl_t             s5_ctl_r;

  assign enum_prod = 30'(s4_xm_r) * 30'(LOG2_10_Q16);

  always_comb begin
    num_nxt = '0;
    den_nxt = DEN_W'(s4_d_r);
    ctl_nxt.in_range = s4_inr_r;
    ctl_nxt.mode     = MODE_ZERO;
    if (s4_inr_r) begin
      case (s4_shape_r)
        SHAPE_BOX: begin
          ctl_nxt.mode = MODE_ONE;
        end
        SHAPE_TRI: begin
          ctl_nxt.mode = MODE_DIV;
          num_nxt = (NUM_W'(s4_d_r - LEN_W'(s4_t_r)) << AMP_FRAC_BITS)
                  + NUM_W'(s4_d_r >> 1);
        end
        SHAPE_BELL: begin
          ctl_nxt.mode = MODE_POW;
          num_nxt = (NUM_W'(s4_gnum_r) << 2) + NUM_W'(s4_dd_r >> 1);
          den_nxt = s4_dd_r;
        end
        default: begin
          ctl_nxt.mode = s4_flat_r ? MODE_ONE : MODE_POW;
          num_nxt = NUM_W'(enum_prod) + NUM_W'(s4_span_r >> 1);
          den_nxt = DEN_W'(s4_span_r);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r     <= in_sample_index;
      s1_d_r     <= d_in;
      s1_t_r     <= t_in[IDX_W-1:0];
      s1_inr_r   <= LEN_W'(in_sample_index) < d_in;
      s1_shape_r <= shape_r;

      s2_x_r     <= s1_x_r;
      s2_d_r     <= s1_d_r;
      s2_t_r     <= s1_t_r;
      s2_inr_r   <= s1_inr_r;
      s2_shape_r <= s1_shape_r;
      s2_tt_r    <= 24'(s1_t_r) * 24'(s1_t_r);
      s2_dd_r    <= DEN_W'(s1_d_r) * DEN_W'(s1_d_r);
      s2_d5_r    <= 29'(s1_d_r) * 29'(DIV5_MUL);

      s3_x_r     <= s2_x_r;
      s3_d_r     <= s2_d_r;
      s3_t_r     <= s2_t_r;
      s3_inr_r   <= s2_inr_r;
      s3_shape_r <= s2_shape_r;
      s3_dd_r    <= s2_dd_r;
      s3_flat_r  <= LEN_W'(s2_d5_r >> DIV5_SHIFT);
      s3_gnum_r  <= 41'(s2_tt_r) * 41'(LOG2E_Q16);

      s4_d_r     <= s3_d_r;
      s4_t_r     <= s3_t_r;
      s4_inr_r   <= s3_inr_r;
      s4_shape_r <= s3_shape_r;
      s4_dd_r    <= s3_dd_r;
      s4_gnum_r  <= s3_gnum_r;
      s4_xm_r    <= IDX_W'(LEN_W'(s3_x_r) - s3_flat_r);
      s4_span_r  <= s3_d_r - s3_flat_r;
      s4_flat_r  <= LEN_W'(s3_x_r) < s3_flat_r;

      s5_num_r   <= num_nxt;
      s5_den_r   <= den_nxt;
      s5_ctl_r   <= ctl_nxt;
    end
  end

  logic              div_vld;
  logic [QUOT_W-1:0] div_quot;
  ctl_t              div_ctl;

  ssg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s5_v_r),
    .num     (s5_num_r),
    .den     (s5_den_r),
    .in_ctl  (s5_ctl_r),
    .out_vld (div_vld),
    .quot    (div_quot),
    .out_ctl (div_ctl)
  );

  ssg_pow2 u_pow2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (div_vld),
    .y        (div_quot),
    .in_ctl   (div_ctl),
    .out_vld  (out_valid),
    .amp      (out_amplitude),
    .in_range (out_in_range)
  );

endmodule

### sv/ssg_div.sv
// Restoring divider pipeline, one quotient bit per register stage.
// Depends on ssg_pkg; carries a control word alongside each beat.
module ssg_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [ssg_pkg::NUM_W-1:0] num,
  input  logic [ssg_pkg::DEN_W-1:0] den,
  input  ssg_pkg::ctl_t             in_ctl,
  output logic                      out_vld,
  output logic [ssg_pkg::QUOT_W-1:0] quot,
  output ssg_pkg::ctl_t             out_ctl
);
  import ssg_pkg::*;

  logic              vld_r  [QUOT_W];
  logic [NUM_W-1:0]  rem_r  [QUOT_W];
  logic [DEN_W-1:0]  den_r  [QUOT_W];
  logic [QUOT_W-1:0] quot_r [QUOT_W];
  ctl_t              ctl_r  [QUOT_W];

  for (genvar i = 0; i < QUOT_W; i++) begin : g_stage
    localparam int K = QUOT_W - 1 - i;
    logic              vld_i;
    logic [NUM_W-1:0]  rem_i;
    logic [DEN_W-1:0]  den_i;
    logic [QUOT_W-1:0] quot_i;
    ctl_t              ctl_i;
    logic [NUM_W-1:0]  trial;
    logic              ge;

    if (i == 0) begin : g_head
      assign vld_i  = in_vld;
      assign rem_i  = num;
      assign den_i  = den;
      assign quot_i = '0;
      assign ctl_i  = in_ctl;
    end else begin : g_body
      assign vld_i  = vld_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign den_i  = den_r[i-1];
      assign quot_i = quot_r[i-1];
      assign ctl_i  = ctl_r[i-1];
    end

    assign trial = NUM_W'(den_i) << K;
    assign ge    = rem_i >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? rem_i - trial : rem_i;
        den_r[i]  <= den_i;
        quot_r[i] <= quot_i | (QUOT_W'(ge) << K);
        ctl_r[i]  <= ctl_i;
      end
    end
  end

  assign out_vld = vld_r[QUOT_W-1];
  assign quot    = quot_r[QUOT_W-1];
  assign out_ctl = ctl_r[QUOT_W-1];

endmodule

### sv/ssg_pow2.sv
// 2^-y pipeline (one Q30 multiply per fraction bit) and the output register.
// Depends on ssg_pkg; selects the final amplitude from the control word.
module ssg_pow2 (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [ssg_pkg::QUOT_W-1:0] y,
  input  ssg_pkg::ctl_t              in_ctl,
  output logic                       out_vld,
  output logic [ssg_pkg::AMP_W-1:0]  amp,
  output logic                       in_range
);
  import ssg_pkg::*;

  localparam int PROD_W = M_W + R_W;

  logic              vld_r [FRAC_W];
  logic [M_W-1:0]    m_r   [FRAC_W];
  logic [QUOT_W-1:0] y_r   [FRAC_W];
  ctl_t              ctl_r [FRAC_W];

  for (genvar j = 0; j < FRAC_W; j++) begin : g_stage
    localparam int K = FRAC_W - 1 - j;
    logic              vld_i;
    logic [M_W-1:0]    m_i;
    logic [QUOT_W-1:0] y_i;
    ctl_t              ctl_i;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] prod_rnd;

    if (j == 0) begin : g_head
      assign vld_i = in_vld;
      assign m_i   = M_W'(1) << R_W;
      assign y_i   = y;
      assign ctl_i = in_ctl;
    end else begin : g_body
      assign vld_i = vld_r[j-1];
      assign m_i   = m_r[j-1];
      assign y_i   = y_r[j-1];
      assign ctl_i = ctl_r[j-1];
    end

    assign prod     = PROD_W'(m_i) * PROD_W'(R_TAB[j]);
    assign prod_rnd = prod + (PROD_W'(1) << (R_W - 1));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[j]   <= y_i[K] ? prod_rnd[R_W +: M_W] : m_i;
        y_r[j]   <= y_i;
        ctl_r[j] <= ctl_i;
      end
    end
  end

  // scale Q30 down to the amplitude format plus the integer part of y
  localparam int BASE_SHIFT = R_W - AMP_FRAC_BITS;

  logic              fin_vld;
  logic [M_W-1:0]    fin_m;
  logic [QUOT_W-1:0] fin_y;
  ctl_t              fin_ctl;
  logic [EXP_W-1:0]  n;
  logic [M_W:0]      m_rnd;
  logic [M_W:0]      m_shr;
  logic [AMP_W-1:0]  amp_nxt;
  logic              out_vld_r;
  logic [AMP_W-1:0]  amp_r;
  logic              in_range_r;

  assign fin_vld = vld_r[FRAC_W-1];
  assign fin_m   = m_r[FRAC_W-1];
  assign fin_y   = y_r[FRAC_W-1];
  assign fin_ctl = ctl_r[FRAC_W-1];
  assign n       = fin_y[QUOT_W-1 -: EXP_W];
  assign m_rnd   = (M_W+1)'(fin_m) + ((M_W+1)'(1) << (BASE_SHIFT - 1 + int'(n)));
  assign m_shr   = m_rnd >> (BASE_SHIFT + int'(n));

  always_comb begin
    unique case (fin_ctl.mode)
      MODE_ZERO: amp_nxt = '0;
      MODE_ONE:  amp_nxt = AMP_ONE;
      MODE_DIV:  amp_nxt = fin_y[AMP_W-1:0];
      MODE_POW:  amp_nxt = m_shr[AMP_W-1:0];
      default:   amp_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= fin_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amp_r      <= amp_nxt;
      in_range_r <= fin_ctl.in_range;
    end
  end

  assign out_vld  = out_vld_r;
  assign amp      = amp_r;
  assign in_range = in_range_r;

endmodule

### sv/ssg_checker.sv
// Port-level checks for the spike-shape sample generator.
// Depends on ssg_pkg; bound to spike_shape_sample_generator_top below.
module ssg_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [ssg_pkg::AMP_W-1:0]  out_amplitude,
  input logic                       out_in_range
);
  import ssg_pkg::*;

  a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_amplitude)
      && $stable(out_in_range))
    else $error("output beat changed while stalled");

  a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

  a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> out_amplitude == '0)
    else $error("nonzero amplitude out of range");

  a_amp_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_amplitude <= AMP_ONE)
    else $error("amplitude above one");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind spike_shape_sample_generator_top ssg_checker u_ssg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_amplitude (out_amplitude),
  .out_in_range  (out_in_range)
);

### sim/testbench.sv
// Testbench for the spike-shape sample generator: directed and random sample
// indices under several shape/length settings, checked against a local model.
// Depends on ssg_pkg and spike_shape_sample_generator_top.
`timescale 1ns / 100ps

module testbench;
  import ssg_pkg::*;

  // index with no register behind it
  localparam logic [CIDX_W-1:0] REG_NONE = 2'd3;

  typedef struct {
    logic [AMP_W-1:0] amp;
    logic             in_rng;
  } sample_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CIDX_W-1:0]    cfg_index;
  logic [LEN_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [IDX_W-1:0]     in_sample_index;
  logic                 out_valid;
  logic                 out_stall;
  logic [AMP_W-1:0]     out_amplitude;
  logic                 out_in_range;

  logic [1:0]  cur_shape;
  logic [12:0] cur_length;
  sample_t     expected_samples[$];
  int          mismatches;
  int          beats_sent;
  int          beats_checked;
  int          send_idle_pct;
  int          recv_stall_pct;

  spike_shape_sample_generator_top u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_index(in_sample_index), .out_valid(out_valid),
    .out_stall(out_stall), .out_amplitude(out_amplitude),
    .out_in_range(out_in_range)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v   = v_in;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^-y, y in Q16, result in Q1.15
  function automatic logic [63:0] exp2_neg(input logic [63:0] y);
    logic [63:0] n;
    logic [63:0] m;
    logic [63:0] r;
    logic [63:0] sh;
    n = y >> 16;
    m = 64'd1 << 30;
    r = int_sqrt(64'd1 << 59);
    for (int k = 15; k >= 0; k--) begin
      if (y[k]) m = (m * r + (64'd1 << 29)) >> 30;
      r = int_sqrt(r << 30);
    end
    sh = 64'(30 - AMP_FRAC_BITS) + n;
    if (sh >= 63) return 0;
    return (m + (64'd1 << (sh - 1))) >> sh;
  endfunction

  function automatic sample_t spike_sample(input logic [IDX_W-1:0] idx);
    sample_t     s;
    logic [63:0] x;
    logic [63:0] d;
    logic [63:0] t;
    logic [63:0] y;
    logic [63:0] amp;
    logic [63:0] flat;
    x = idx;
    d = cur_length;
    if (d > MAX_LENGTH) d = MAX_LENGTH;
    s.amp    = '0;
    s.in_rng = 1'b0;
    if (x >= d) return s;
    t = (2 * x + 1 >= d) ? 2 * x + 1 - d : d - 2 * x - 1;
    case (cur_shape)
      SHAPE_BOX: amp = 64'd1 << AMP_FRAC_BITS;
      SHAPE_TRI: amp = (((d - t) << AMP_FRAC_BITS) + d / 2) / d;
      SHAPE_BELL: begin
        y   = (4 * t * t * 64'(LOG2E_Q16) + d * d / 2) / (d * d);
        amp = exp2_neg(y);
      end
      default: begin
        flat = d / 5;
        if (x < flat) begin
          amp = 64'd1 << AMP_FRAC_BITS;
        end else begin
          y   = ((x - flat) * 64'(LOG2_10_Q16) + (d - flat) / 2) / (d - flat);
          amp = exp2_neg(y);
        end
      end
    endcase
    s.amp    = amp[AMP_W-1:0];
    s.in_rng = 1'b1;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR beat %0d: %s got %0d expected %0d (shape %0d len %0d)",
             beats_checked, what, got, want, cur_shape, cur_length);
    mismatches++;
  endtask

  // receiver: random stall, check each output beat
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        report_mismatch("unexpected beat, amplitude", out_amplitude, -1);
      end else begin
        want = expected_samples.pop_front();
        if (out_amplitude !== want.amp)
          report_mismatch("amplitude", out_amplitude, want.amp);
        if (out_in_range !== want.in_rng)
          report_mismatch("in_range", out_in_range, want.in_rng);
      end
      beats_checked++;
    end
  end

  // valid stays high between back-to-back beats; drop it only while idle
  task automatic send_index(input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_samples.push_back(spike_sample(idx));
    beats_sent++;
    @(negedge clk);
  endtask

  // drain, then let the pipeline empty before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [LEN_W-1:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SHAPE) cur_shape = val[1:0];
    else if (idx == REG_LENGTH) cur_length = val;
  endtask

  task automatic set_spike(input logic [1:0] shp, input logic [LEN_W-1:0] len);
    write_reg(REG_SHAPE, LEN_W'(shp));
    write_reg(REG_LENGTH, len);
  endtask

  task automatic test_reset_state();
    send_index(0);
    send_index(1);
    send_index(12'hFFF);
  endtask

  task automatic test_directed();
    logic [1:0] shp;
    for (int s = 0; s < 4; s++) begin
      shp = s[1:0];
      set_spike(shp, 13'd4096);
      send_index(0);
      send_index(2047);
      send_index(2048);
      send_index(12'hFFF);
      set_spike(shp, 13'd5);
      send_index(0);
      send_index(4);
      send_index(5);
    end
    // zero length, above the limit, and an unused register index
    set_spike(SHAPE_TRI, 13'd0);
    send_index(0);
    set_spike(SHAPE_BELL, 13'h1FFF);
    send_index(12'hFFF);
    send_index(12'hAAA);
    send_index(12'h555);
    write_reg(REG_NONE, 13'd7);
    send_index(0);
  endtask

  task automatic test_random(input int n_items);
    int len_pick;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) begin
        len_pick = $urandom_range(9);
        set_spike(2'($urandom_range(3)),
                  len_pick == 0 ? 13'($urandom_range(13'h1FFF)) :
                  len_pick < 4  ? 13'($urandom_range(4096, 1)) :
                                  13'($urandom_range(64, 1)));
      end
      if ($urandom_range(9) == 0)
        send_index(12'($urandom_range(12'hFFF)));
      else
        send_index(12'($urandom_range(cur_length == 0 ? 0 :
                   (cur_length > 4096 ? 4095 : cur_length - 1))));
    end
  endtask

  task automatic test_idling(input int snd, input int rcv, input int n_items);
    wait_idle();
    send_idle_pct  = snd;
    recv_stall_pct = rcv;
    test_random(n_items);
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 1'b0; in_sample_index = '0; out_stall = 1'b0;
    cur_shape = SHAPE_BOX; cur_length = 13'd1;
    mismatches = 0; beats_sent = 0; beats_checked = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_state();
    test_directed();
    test_idling(0, 0, 200);
    test_idling(88, 0, 150);
    test_idling(0, 88, 150);
    test_idling(21, 21, 150);
    wait_idle();
    $display("Sent %0d sample indices over all four shapes, lengths 0 to 8191,",
             beats_sent);
    $display("with sender gaps and receiver stalls; %0d mismatches.", mismatches);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule
